/* design/rfa_pkg.sv */
// ----------------------------------------------------------------------------
// rfa_pkg
// Types and constants of the rational fraction adder.
// ----------------------------------------------------------------------------
package rfa_pkg;

  localparam int DataWidth = 32;
  localparam int MagWidth  = 64;

  localparam logic [1:0] ErrNone     = 2'd0;
  localparam logic [1:0] ErrZeroDen  = 2'd1;
  localparam logic [1:0] ErrOverflow = 2'd2;

  typedef struct packed {
    logic signed [31:0] first_numerator;
    logic signed [31:0] first_denominator;
    logic signed [31:0] second_numerator;
    logic signed [31:0] second_denominator;
  } in_item_t;

  typedef struct packed {
    logic signed [31:0] sum_numerator;
    logic [30:0]        sum_denominator;
    logic [1:0]         error_code;
  } out_item_t;

  typedef enum logic [3:0] {
    ST_IDLE, ST_GCD1, ST_DIV1, ST_DIV2, ST_MUL2, ST_MUL3,
    ST_ADD, ST_GCD2, ST_DIV4, ST_DIV5, ST_CHECK, ST_OUT
  } state_t;

  typedef struct packed {
    logic start;
    logic busy;
  } div_ctl_t;

endpackage

/* design/rfa_divider.sv */
// ----------------------------------------------------------------------------
// rfa_divider
// Restoring divider: one quotient bit a cycle over 64-bit magnitudes.
// ----------------------------------------------------------------------------
module rfa_divider (
  input  logic                     clk,
  input  logic                     rst_n,
  input  logic                     start,
  input  logic [rfa_pkg::MagWidth-1:0] dividend,
  input  logic [rfa_pkg::MagWidth-1:0] divisor,
  output rfa_pkg::div_ctl_t        ctl,
  output logic [rfa_pkg::MagWidth-1:0] quotient,
  output logic [rfa_pkg::MagWidth-1:0] remainder
);
  import rfa_pkg::*;

  logic [MagWidth-1:0] q_r, q_nxt, r_r, r_nxt, d_r, d_nxt;
  logic [6:0]          cnt_r, cnt_nxt;
  logic                busy_r, busy_nxt;
  logic [MagWidth:0]   trial;

  always_comb begin
    q_nxt    = q_r;
    r_nxt    = r_r;
    d_nxt    = d_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    trial    = {r_r, q_r[MagWidth-1]} - {1'b0, d_r};
    if (start) begin
      q_nxt    = dividend;
      r_nxt    = '0;
      d_nxt    = divisor;
      cnt_nxt  = 7'(MagWidth);
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[MagWidth]) begin
        r_nxt = trial[MagWidth-1:0];
        q_nxt = {q_r[MagWidth-2:0], 1'b1};
      end else begin
        r_nxt = {r_r[MagWidth-2:0], q_r[MagWidth-1]};
        q_nxt = {q_r[MagWidth-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - 7'd1;
      if (cnt_r == 7'd1) busy_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      cnt_r  <= cnt_nxt;
    end
    q_r <= q_nxt;
    r_r <= r_nxt;
    d_r <= d_nxt;
  end

  assign ctl.start = start;
  assign ctl.busy  = busy_r;
  assign quotient  = q_r;
  assign remainder = r_r;

endmodule

/* design/rational_fraction_adder.sv */
// ----------------------------------------------------------------------------
// rational_fraction_adder
// Adds two signed fractions and returns the sum in lowest terms.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel in_valid/in_stall/in_data carries both fractions; result
//   channel out_valid/out_stall/out_data returns one transaction per input.
//   Each transaction runs through a sequencer around one shared 64-bit
//   restoring divider; a division has a start step, 64 quotient bits and
//   a collect step. Each Euclid step is one division; the three 32x32
//   products use one multiplier, the first one in the collect step of a
//   division. The result follows the first GCD, two divisions, the products,
//   the add, the second GCD, two more divisions and the check; a zero
//   sum skips the second GCD, its divisions and the check, and a zero
//   denominator is reported in the cycle right after acceptance. in_stall is
//   high whenever a transaction is in flight; the next input is accepted
//   in the cycle after the result is taken. The result is held in an output
//   register until accepted; a stalled result holds its payload. Reset
//   clears the sequencer and drops any transaction in progress.
// ----------------------------------------------------------------------------
module rational_fraction_adder (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  rfa_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output rfa_pkg::out_item_t out_data
);
  import rfa_pkg::*;

  localparam logic [63:0] Limit = 64'd1 << (DataWidth - 1);

  state_t state_r, state_nxt;
  logic [63:0] a_r, a_nxt, b_r, b_nxt;
  logic [63:0] d1_r, d1_nxt, d2_r, d2_nxt, n1_r, n1_nxt, n2_r, n2_nxt;
  logic [63:0] g_r, g_nxt, lcm_r, lcm_nxt, t1_r, t1_nxt, t2_r, t2_nxt;
  logic [63:0] num_r, num_nxt;
  logic        neg1_r, neg1_nxt, neg2_r, neg2_nxt, negs_r, negs_nxt;
  logic        started_r, started_nxt;
  out_item_t   res_r, res_nxt;
  logic        ov;

  logic        div_start;
  logic [63:0] div_a, div_b, div_q, div_rem;
  div_ctl_t    div_ctl;
  logic [31:0] mul_x, mul_y;
  logic [63:0] mul_p;

  logic        sn1, sd1, sn2, sd2;
  logic [31:0] mn1, md1, mn2, md2;

  rfa_divider u_div (
    .clk, .rst_n, .start(div_start), .dividend(div_a), .divisor(div_b),
    .ctl(div_ctl), .quotient(div_q), .remainder(div_rem)
  );

  assign mul_p = 64'(mul_x) * 64'(mul_y);

  function automatic logic [31:0] mag_of(input logic [31:0] v);
    logic [31:0] m;
    m = v[DataWidth-1] ? (32'd0 - v) : v;
    return m;
  endfunction

  always_comb begin
    sn1 = in_data.first_numerator[DataWidth-1];
    sd1 = in_data.first_denominator[DataWidth-1];
    sn2 = in_data.second_numerator[DataWidth-1];
    sd2 = in_data.second_denominator[DataWidth-1];
    mn1 = mag_of(32'(in_data.first_numerator));
    md1 = mag_of(32'(in_data.first_denominator));
    mn2 = mag_of(32'(in_data.second_numerator));
    md2 = mag_of(32'(in_data.second_denominator));
  end

  always_comb begin
    state_nxt = state_r; a_nxt = a_r; b_nxt = b_r;
    d1_nxt = d1_r; d2_nxt = d2_r; n1_nxt = n1_r; n2_nxt = n2_r;
    g_nxt = g_r; lcm_nxt = lcm_r; t1_nxt = t1_r; t2_nxt = t2_r;
    num_nxt = num_r; neg1_nxt = neg1_r; neg2_nxt = neg2_r; negs_nxt = negs_r;
    started_nxt = started_r; res_nxt = res_r; ov = 1'b0;
    div_start = 1'b0; div_a = a_r; div_b = b_r;
    mul_x = '0; mul_y = '0;
    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          d1_nxt = 64'(md1); d2_nxt = 64'(md2);
          n1_nxt = 64'(mn1); n2_nxt = 64'(mn2);
          neg1_nxt = (sn1 != sd1) && (mn1 != '0);
          neg2_nxt = (sn2 != sd2) && (mn2 != '0);
          a_nxt = 64'(md1); b_nxt = 64'(md2);
          started_nxt = 1'b0;
          if (md1 == '0 || md2 == '0) begin
            res_nxt = '{sum_numerator: '0, sum_denominator: '0, error_code: ErrZeroDen};
            state_nxt = ST_OUT;
          end else begin
            state_nxt = ST_GCD1;
          end
        end
      end
      ST_GCD1, ST_GCD2: begin
        if (!started_r) begin
          if (b_r == '0) begin
            g_nxt = a_r;
            state_nxt = (state_r == ST_GCD1) ? ST_DIV1 : ST_DIV4;
          end else begin
            div_start = 1'b1;
            started_nxt = 1'b1;
          end
        end else if (!div_ctl.busy) begin
          a_nxt = b_r; b_nxt = div_rem; started_nxt = 1'b0;
        end
      end
      ST_DIV1, ST_DIV2, ST_DIV4, ST_DIV5: begin
        unique case (state_r)
          ST_DIV1: begin div_a = d1_r;  div_b = g_r; end
          ST_DIV2: begin div_a = d2_r;  div_b = g_r; end
          ST_DIV4: begin div_a = num_r; div_b = g_r; end
          default: begin div_a = lcm_r; div_b = g_r; end
        endcase
        if (!started_r) begin
          div_start = 1'b1; started_nxt = 1'b1;
        end else if (!div_ctl.busy) begin
          started_nxt = 1'b0;
          unique case (state_r)
            ST_DIV1: begin d1_nxt = div_q; state_nxt = ST_DIV2; end
            ST_DIV2: begin
              mul_x = d1_r[31:0]; mul_y = d2_r[31:0];
              lcm_nxt = mul_p; d2_nxt = div_q; state_nxt = ST_MUL2;
            end
            ST_DIV4: begin num_nxt = div_q; state_nxt = ST_DIV5; end
            default: begin lcm_nxt = div_q; state_nxt = ST_CHECK; end
          endcase
        end
      end
      ST_MUL2: begin
        mul_x = n1_r[31:0]; mul_y = d2_r[31:0];
        t1_nxt = mul_p; state_nxt = ST_MUL3;
      end
      ST_MUL3: begin
        mul_x = n2_r[31:0]; mul_y = d1_r[31:0];
        t2_nxt = mul_p; state_nxt = ST_ADD;
      end
      ST_ADD: begin
        if (neg1_r == neg2_r) begin
          num_nxt = t1_r + t2_r; negs_nxt = neg1_r;
        end else if (t1_r >= t2_r) begin
          num_nxt = t1_r - t2_r; negs_nxt = neg1_r;
        end else begin
          num_nxt = t2_r - t1_r; negs_nxt = neg2_r;
        end
        if (num_nxt == '0) begin
          res_nxt = '{sum_numerator: '0, sum_denominator: 31'd1, error_code: ErrNone};
          state_nxt = ST_OUT;
        end else begin
          a_nxt = num_nxt; b_nxt = lcm_r; state_nxt = ST_GCD2;
        end
      end
      ST_CHECK: begin
        ov = (lcm_r > Limit - 64'd1) ||
             (negs_r ? (num_r > Limit) : (num_r > Limit - 64'd1));
        if (ov) begin
          res_nxt = '{sum_numerator: '0, sum_denominator: '0, error_code: ErrOverflow};
        end else begin
          res_nxt.sum_numerator   = negs_r ? (32'd0 - num_r[31:0]) : num_r[31:0];
          res_nxt.sum_denominator = lcm_r[30:0];
          res_nxt.error_code      = ErrNone;
        end
        state_nxt = ST_OUT;
      end
      ST_OUT: begin
        if (!out_stall) state_nxt = ST_IDLE;
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= ST_IDLE;
      started_r <= 1'b0;
    end else begin
      state_r   <= state_nxt;
      started_r <= started_nxt;
    end
    a_r <= a_nxt; b_r <= b_nxt; d1_r <= d1_nxt; d2_r <= d2_nxt;
    n1_r <= n1_nxt; n2_r <= n2_nxt; g_r <= g_nxt; lcm_r <= lcm_nxt;
    t1_r <= t1_nxt; t2_r <= t2_nxt; num_r <= num_nxt;
    neg1_r <= neg1_nxt; neg2_r <= neg2_nxt; negs_r <= negs_nxt;
    res_r <= res_nxt;
  end

  assign in_stall  = (state_r != ST_IDLE);
  assign out_valid = (state_r == ST_OUT);
  assign out_data  = res_r;

endmodule

/* tb/rfa_checker.sv */
// ----------------------------------------------------------------------------
// rfa_checker
// Watches both channels of the rational fraction adder, computes the reduced
// sum of every accepted transaction and compares it with the returned one.
// ----------------------------------------------------------------------------
module rfa_checker (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  input  logic               in_stall,
  input  rfa_pkg::in_item_t  in_data,
  input  logic               out_valid,
  input  logic               out_stall,
  input  rfa_pkg::out_item_t out_data,
  output int                 fail_count,
  output int                 pending_sums,
  output int                 sums_checked,
  output int                 err_seen [3]
);
  import rfa_pkg::*;

  out_item_t expected_sums [$];

  initial begin
    fail_count = 0;
    sums_checked = 0;
    err_seen = '{0, 0, 0};
  end

  assign pending_sums = expected_sums.size();

  function automatic logic [63:0] gcd64(logic [63:0] a, logic [63:0] b);
    logic [63:0] r;
    while (b != 0) begin
      r = a % b;
      a = b;
      b = r;
    end
    return a;
  endfunction

  function automatic void to_sign_mag(logic [31:0] raw, output logic neg,
                                      output logic [63:0] mag);
    neg = raw[DataWidth-1];
    mag = neg ? (64'd1 << DataWidth) - {32'd0, raw} : {32'd0, raw};
  endfunction

  function automatic out_item_t fraction_sum(in_item_t x);
    out_item_t   res;
    logic        sn1, sd1, sn2, sd2, neg1, neg2, negs;
    logic [63:0] n1, d1, n2, d2, g, lcm, t1, t2, num, den, r, lim;
    to_sign_mag(x.first_numerator, sn1, n1);
    to_sign_mag(x.first_denominator, sd1, d1);
    to_sign_mag(x.second_numerator, sn2, n2);
    to_sign_mag(x.second_denominator, sd2, d2);
    res = '0;
    lim = 64'd1 << (DataWidth - 1);
    if (d1 == 0 || d2 == 0) begin
      res.error_code = ErrZeroDen;
      return res;
    end
    neg1 = (sn1 != sd1) && n1 != 0;
    neg2 = (sn2 != sd2) && n2 != 0;
    g = gcd64(d1, d2);
    lcm = (d1 / g) * d2;
    t1 = n1 * (d2 / g);
    t2 = n2 * (d1 / g);
    if (neg1 == neg2) begin
      num = t1 + t2;
      negs = neg1;
    end else if (t1 >= t2) begin
      num = t1 - t2;
      negs = neg1;
    end else begin
      num = t2 - t1;
      negs = neg2;
    end
    if (num == 0) begin
      res.sum_denominator = 31'd1;
      res.error_code = ErrNone;
      return res;
    end
    r = gcd64(num, lcm);
    num = num / r;
    den = lcm / r;
    if (den > lim - 1 || (negs ? num > lim : num > lim - 1)) begin
      res.error_code = ErrOverflow;
      return res;
    end
    res.sum_numerator = negs ? 32'(64'd0 - num) : num[31:0];
    res.sum_denominator = den[30:0];
    res.error_code = ErrNone;
    return res;
  endfunction

  always @(posedge clk) begin
    out_item_t want;
    if (rst_n) begin
      if (in_valid && !in_stall)
        expected_sums.push_back(fraction_sum(in_data));
      if (out_valid && !out_stall) begin
        if (expected_sums.size() == 0) begin
          $display("%0t: unexpected transaction %h", $time, out_data);
          fail_count <= fail_count + 1;
        end else begin
          want = expected_sums.pop_front();
          sums_checked <= sums_checked + 1;
          if (out_data.error_code <= ErrOverflow)
            err_seen[out_data.error_code] <= err_seen[out_data.error_code] + 1;
          if (want.sum_numerator !== out_data.sum_numerator ||
              want.sum_denominator !== out_data.sum_denominator ||
              want.error_code !== out_data.error_code) begin
            $display("%0t: mismatch expected %0d/%0d err %0d, actual %0d/%0d err %0d",
                     $time, want.sum_numerator, want.sum_denominator,
                     want.error_code, out_data.sum_numerator,
                     out_data.sum_denominator, out_data.error_code);
            fail_count <= fail_count + 1;
          end
        end
      end
    end
  end

endmodule

/* tb/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Drives directed and random fraction pairs into the rational fraction adder
// with bursty input and patterned output stall; the checker judges results.
// ----------------------------------------------------------------------------
module tb;
  import rfa_pkg::*;

  logic      clk;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  int        fail_count;
  int        pending_sums;
  int        sums_checked;
  int        err_seen [3];
  logic      stim_done;
  logic      hold_off;
  int        sent;

  rational_fraction_adder dut (.*);

  rfa_checker u_checker (.*);

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [31:0] pick_value(bit for_den);
    case ($urandom_range(0, 9))
      0: return 32'h8000_0000;
      1: return 32'h7fff_ffff;
      2: return for_den ? 32'd0 : 32'hffff_ffff;
      3, 4: return 32'($signed($urandom_range(0, 40)) - 20);
      5, 6: return 32'($signed($urandom_range(0, 2000)) - 1000);
      7: return $urandom & 32'h0000_ffff;
      default: return $urandom;
    endcase
  endfunction

  task automatic offer_pair(logic [31:0] n1, logic [31:0] d1,
                            logic [31:0] n2, logic [31:0] d2);
    in_valid <= 1'b1;
    in_data  <= '{n1, d1, n2, d2};
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sent++;
  endtask

  task automatic idle_gap(int cycles);
    if (cycles > 0) begin
      in_valid <= 1'b0;
      repeat (cycles) @(posedge clk);
    end
  endtask

  initial begin
    logic [31:0] d1, d2;
    int burst;
    rst_n     = 1'b0;
    in_valid  = 1'b0;
    in_data   = '0;
    stim_done = 1'b0;
    sent      = 0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    offer_pair(32'd1, 32'd2, 32'd1, 32'd3);
    offer_pair(32'd1, 32'd2, -32'sd1, 32'd2);
    offer_pair(32'd3, -32'sd4, 32'd1, 32'd4);
    offer_pair(-32'sd5, -32'sd6, 32'd1, 32'd6);
    offer_pair(32'd1, 32'd0, 32'd1, 32'd2);
    offer_pair(32'd1, 32'd2, 32'd1, 32'd0);
    offer_pair(32'd0, 32'd0, 32'd0, 32'd0);
    offer_pair(32'h8000_0000, 32'd1, 32'h8000_0000, 32'd1);
    offer_pair(32'h8000_0000, 32'd1, 32'd0, 32'd7);
    offer_pair(32'h8000_0000, 32'hffff_ffff, 32'd0, 32'd1);
    offer_pair(32'h7fff_ffff, 32'd1, 32'd1, 32'd1);
    offer_pair(32'h7fff_ffff, 32'd1, 32'h8000_0000, 32'd1);
    offer_pair(32'd1, 32'h7fff_ffff, 32'd1, 32'h7fff_fffe);
    offer_pair(32'd1, 32'h8000_0000, 32'd1, 32'h8000_0000);
    offer_pair(32'd1, 32'h8000_0000, 32'd0, 32'd1);
    offer_pair(32'hffff_ffff, 32'h8000_0000, 32'd0, 32'd3);
    offer_pair(32'h8000_0000, 32'h8000_0000, 32'h7fff_ffff, 32'h7fff_ffff);
    offer_pair(32'd6, 32'd9, 32'd4, 32'd6);
    offer_pair(32'd0, -32'sd3, 32'd0, 32'd5);
    offer_pair(32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff);
    while (sent < 1250) begin
      burst = $urandom_range(1, 12);
      repeat (burst) begin
        d1 = pick_value(1'b1);
        d2 = pick_value(1'b1);
        if ($urandom_range(0, 9) != 0) begin
          if (d1 == 0) d1 = 32'd1;
          if (d2 == 0) d2 = 32'd3;
        end
        offer_pair(pick_value(1'b0), d1, pick_value(1'b0), d2);
        if ($urandom_range(0, 3) == 0) idle_gap($urandom_range(1, 4));
      end
      idle_gap($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 300));
    end
    in_valid  <= 1'b0;
    stim_done <= 1'b1;
  end

  initial begin
    hold_off = 1'b0;
    @(posedge rst_n);
    repeat (200) @(posedge clk);
    hold_off <= 1'b1;
    repeat (20000) @(posedge clk);
    hold_off <= 1'b0;
  end

  always @(posedge clk) begin
    int phase;
    phase = int'(($time / 10) % 4096);
    if (!rst_n || hold_off)
      out_stall <= 1'b1;
    else if (phase < 1024)
      out_stall <= 1'b0;
    else if (phase < 2048)
      out_stall <= ($urandom_range(0, 1) == 0);
    else
      out_stall <= ($urandom_range(0, 31) < 3);
  end

  initial begin
    wait (stim_done === 1'b1);
    while (pending_sums != 0) @(posedge clk);
    repeat (5000) @(posedge clk);
    $display("covered %0d fraction pairs, %0d sums checked", sent, sums_checked);
    $display("ok %0d, zero denominator %0d, overflow %0d",
             err_seen[0], err_seen[1], err_seen[2]);
    if (fail_count == 0)
      $display("tb: success");
    else
      $display("tb: failure");
    $finish;
  end

  initial begin
    #1_000_000_000;
    $display("tb: failure");
    $finish;
  end

endmodule
